FILE: sv/ihex_pkg.sv
// ============================================================================
// ihex_pkg: shared types and constants of the Intel HEX record decoder
// Parse phases, result kinds, error codes and the hex digit decode.
// ============================================================================
`default_nettype none

package ihex_pkg;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_LEN  = 3'd1,
        PH_AHI  = 3'd2,
        PH_ALO  = 3'd3,
        PH_TYPE = 3'd4,
        PH_DATA = 3'd5,
        PH_CHK  = 3'd6,
        PH_SKIP = 3'd7
    } phase_t;

    localparam logic [2:0] KIND_DATA_BYTE = 3'd0;
    localparam logic [2:0] KIND_DATA_OK   = 3'd1;
    localparam logic [2:0] KIND_EOF_OK    = 3'd2;
    localparam logic [2:0] KIND_EXT_OK    = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_START = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
    localparam logic [2:0] ERR_BAD_TYPE  = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
    localparam logic [2:0] ERR_LENGTH    = 3'd5;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_EXT  = 8'h04;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam int OUT_DATA_W = 112;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            d.value = c[3:0] + 4'd9;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: sv/intel_hex_record_decoder_top.sv
// ============================================================================
// intel_hex_record_decoder_top: Intel HEX text to addressed data bytes
// One character per beat in; data bytes, record status and errors out.
// ============================================================================
// Each character beat is decoded in the cycle it is accepted and its result,
// if any, lands in the output register, so the block takes one character per
// clock while the output side keeps up. While a result waits in the output
// register and the output side is not ready, the input is stalled. The record
// start address and end address are registered when the address and type
// bytes complete, which keeps the per character path to one 32-bit increment
// or compare.
`default_nettype none

module intel_hex_record_decoder_top
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // in_char
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // byte_address[31:0], byte_value[39:32], error_code[42:40],
    // lowest_address[74:43], highest_address[106:75], range_valid[107], zero fill
    output logic [ihex_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]        m_tuser    // kind
);

    ihex_pkg::phase_t phase_reg, phase_next;
    logic        nib_pend_reg, nib_pend_next;
    logic [3:0]  high_nib_reg, high_nib_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] rec_addr_reg, rec_addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  idx_reg, idx_next;
    logic [15:0] upper_reg, upper_next;
    logic [15:0] ext_reg, ext_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] end_reg, end_next;
    logic [31:0] data_addr_reg, data_addr_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] high_reg, high_next;
    logic        seen_reg, seen_next;

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [31:0] baddr_reg;
    logic [7:0]  bval_reg;
    logic [2:0]  err_reg;
    logic [31:0] lowo_reg;
    logic [31:0] higho_reg;
    logic        rv_reg;

    logic        emit;
    logic [2:0]  emit_kind;
    logic [31:0] emit_addr;
    logic [7:0]  emit_val;
    logic [2:0]  emit_err;

    logic                 accept;
    logic                 eol;
    ihex_pkg::hex_digit_t dig;
    logic                 byte_done;
    logic [7:0]           cur_byte;
    logic [7:0]           sum_new;
    logic [7:0]           idx_inc;
    logic                 type_bad;
    logic                 ext_len_bad;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign eol       = (s_tdata == ihex_pkg::CHAR_LF) || (s_tdata == ihex_pkg::CHAR_CR);
    assign dig       = ihex_pkg::hex_decode(s_tdata);
    assign cur_byte  = {high_nib_reg, dig.value};
    assign byte_done = nib_pend_reg && dig.ok;
    assign sum_new   = (phase_reg == ihex_pkg::PH_LEN) ? cur_byte : sum_reg + cur_byte;
    assign idx_inc   = idx_reg + 8'd1;
    assign type_bad  = (cur_byte != ihex_pkg::REC_DATA) && (cur_byte != ihex_pkg::REC_EOF)
                       && (cur_byte != ihex_pkg::REC_EXT);
    assign ext_len_bad = (cur_byte == ihex_pkg::REC_EXT) && (len_reg != 8'd2);

    // Parse phase and nibble pairing.
    always_comb
    begin
        phase_next    = phase_reg;
        nib_pend_next = nib_pend_reg;
        if (accept)
        begin
            unique case (phase_reg)
                ihex_pkg::PH_WAIT:
                begin
                    nib_pend_next = 1'b0;
                    if (!eol)
                    begin
                        phase_next = (s_tdata == ihex_pkg::CHAR_COLON) ?
                                     ihex_pkg::PH_LEN : ihex_pkg::PH_SKIP;
                    end
                end
                ihex_pkg::PH_SKIP:
                begin
                    if (eol)
                    begin
                        phase_next = ihex_pkg::PH_WAIT;
                    end
                end
                default:
                begin
                    if (eol)
                    begin
                        phase_next    = ihex_pkg::PH_WAIT;
                        nib_pend_next = 1'b0;
                    end
                    else if (!dig.ok)
                    begin
                        phase_next    = ihex_pkg::PH_SKIP;
                        nib_pend_next = 1'b0;
                    end
                    else if (!nib_pend_reg)
                    begin
                        nib_pend_next = 1'b1;
                    end
                    else
                    begin
                        nib_pend_next = 1'b0;
                        unique case (phase_reg)
                            ihex_pkg::PH_LEN:  phase_next = ihex_pkg::PH_AHI;
                            ihex_pkg::PH_AHI:  phase_next = ihex_pkg::PH_ALO;
                            ihex_pkg::PH_ALO:  phase_next = ihex_pkg::PH_TYPE;
                            ihex_pkg::PH_TYPE:
                            begin
                                if (type_bad || ext_len_bad)
                                begin
                                    phase_next = ihex_pkg::PH_SKIP;
                                end
                                else
                                begin
                                    phase_next = (len_reg != 8'd0) ?
                                                 ihex_pkg::PH_DATA : ihex_pkg::PH_CHK;
                                end
                            end
                            ihex_pkg::PH_DATA:
                            begin
                                if (idx_inc == len_reg)
                                begin
                                    phase_next = ihex_pkg::PH_CHK;
                                end
                            end
                            default:           phase_next = ihex_pkg::PH_SKIP;
                        endcase
                    end
                end
            endcase
        end
    end

    // Record fields, address tracking and the result of each beat.
    always_comb
    begin
        high_nib_next  = high_nib_reg;
        len_next       = len_reg;
        rec_addr_next  = rec_addr_reg;
        type_next      = type_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        upper_next     = upper_reg;
        ext_next       = ext_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        data_addr_next = data_addr_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        seen_next      = seen_reg;
        emit           = 1'b0;
        emit_kind      = ihex_pkg::KIND_ERROR;
        emit_addr      = 32'd0;
        emit_val       = 8'd0;
        emit_err       = ihex_pkg::ERR_NONE;
        if (accept)
        begin
            if (phase_reg == ihex_pkg::PH_WAIT)
            begin
                if (!eol && (s_tdata != ihex_pkg::CHAR_COLON))
                begin
                    emit     = 1'b1;
                    emit_err = ihex_pkg::ERR_BAD_START;
                end
            end
            else if (phase_reg != ihex_pkg::PH_SKIP)
            begin
                if (eol)
                begin
                    emit     = 1'b1;
                    emit_err = ihex_pkg::ERR_LENGTH;
                end
                else if (!dig.ok)
                begin
                    emit     = 1'b1;
                    emit_err = ihex_pkg::ERR_BAD_HEX;
                end
                else if (!nib_pend_reg)
                begin
                    high_nib_next = dig.value;
                end
                else
                begin
                    sum_next = sum_new;
                    unique case (phase_reg)
                        ihex_pkg::PH_LEN:
                        begin
                            len_next = cur_byte;
                        end
                        ihex_pkg::PH_AHI:
                        begin
                            rec_addr_next = {cur_byte, 8'd0};
                        end
                        ihex_pkg::PH_ALO:
                        begin
                            rec_addr_next = {rec_addr_reg[15:8], cur_byte};
                            start_next    = {upper_reg, rec_addr_reg[15:8], cur_byte};
                        end
                        ihex_pkg::PH_TYPE:
                        begin
                            type_next      = cur_byte;
                            idx_next       = 8'd0;
                            ext_next       = 16'd0;
                            data_addr_next = start_reg;
                            end_next       = start_reg + {24'd0, len_reg} - 32'd1;
                            if (type_bad)
                            begin
                                emit     = 1'b1;
                                emit_err = ihex_pkg::ERR_BAD_TYPE;
                            end
                            else if (ext_len_bad)
                            begin
                                emit     = 1'b1;
                                emit_err = ihex_pkg::ERR_LENGTH;
                            end
                        end
                        ihex_pkg::PH_DATA:
                        begin
                            idx_next       = idx_inc;
                            data_addr_next = data_addr_reg + 32'd1;
                            if (type_reg == ihex_pkg::REC_EXT)
                            begin
                                ext_next = {ext_reg[7:0], cur_byte};
                            end
                            if (type_reg == ihex_pkg::REC_DATA)
                            begin
                                emit      = 1'b1;
                                emit_kind = ihex_pkg::KIND_DATA_BYTE;
                                emit_addr = data_addr_reg;
                                emit_val  = cur_byte;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                            if (sum_new != 8'd0)
                            begin
                                emit_err = ihex_pkg::ERR_CHECKSUM;
                            end
                            else if (type_reg == ihex_pkg::REC_DATA)
                            begin
                                emit_kind = ihex_pkg::KIND_DATA_OK;
                                if (len_reg != 8'd0)
                                begin
                                    seen_next = 1'b1;
                                    if (start_reg < low_reg)
                                    begin
                                        low_next = start_reg;
                                    end
                                    if (end_reg > high_reg)
                                    begin
                                        high_next = end_reg;
                                    end
                                end
                            end
                            else if (type_reg == ihex_pkg::REC_EOF)
                            begin
                                emit_kind = ihex_pkg::KIND_EOF_OK;
                            end
                            else
                            begin
                                emit_kind  = ihex_pkg::KIND_EXT_OK;
                                upper_next = ext_reg;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ihex_pkg::PH_WAIT;
            nib_pend_reg  <= 1'b0;
            high_nib_reg  <= 4'd0;
            len_reg       <= 8'd0;
            rec_addr_reg  <= 16'd0;
            type_reg      <= 8'd0;
            sum_reg       <= 8'd0;
            idx_reg       <= 8'd0;
            upper_reg     <= 16'd0;
            ext_reg       <= 16'd0;
            start_reg     <= 32'd0;
            end_reg       <= 32'd0;
            data_addr_reg <= 32'd0;
            low_reg       <= 32'hFFFF_FFFF;
            high_reg      <= 32'd0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            nib_pend_reg  <= nib_pend_next;
            high_nib_reg  <= high_nib_next;
            len_reg       <= len_next;
            rec_addr_reg  <= rec_addr_next;
            type_reg      <= type_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            upper_reg     <= upper_next;
            ext_reg       <= ext_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            data_addr_reg <= data_addr_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            seen_reg      <= seen_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= emit_kind;
            baddr_reg <= emit_addr;
            bval_reg  <= emit_val;
            err_reg   <= emit_err;
            lowo_reg  <= low_next;
            higho_reg <= high_next;
            rv_reg    <= seen_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {4'd0, rv_reg, higho_reg, lowo_reg, err_reg, bval_reg, baddr_reg};

endmodule

`default_nettype wire

FILE: sv/ihex_checker.sv
// ============================================================================
// ihex_checker: port-level checks of the Intel HEX record decoder
// Watches the output beats and the input handshake of the top level.
// ============================================================================
`default_nettype none

module ihex_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [7:0]   s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [ihex_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [2:0]   m_tuser
);

    logic [31:0] baddr;
    logic [7:0]  bval;
    logic [2:0]  err;
    logic [31:0] lowa;
    logic [31:0] higha;
    logic        rv;
    logic        in_beat;

    assign baddr   = m_tdata[31:0];
    assign bval    = m_tdata[39:32];
    assign err     = m_tdata[42:40];
    assign lowa    = m_tdata[74:43];
    assign higha   = m_tdata[106:75];
    assign rv      = m_tdata[107];
    assign in_beat = s_tvalid && s_tready && (s_tdata != 8'h00);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled output beat changed.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("Input stalled with an empty output register.");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == ihex_pkg::KIND_ERROR) == (err != ihex_pkg::ERR_NONE)))
        else $error("Error code does not match the result kind.");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ihex_pkg::KIND_DATA_BYTE) |-> baddr == 32'd0 && bval == 8'd0)
        else $error("Status beat carries a data address or value.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !rv |-> lowa == 32'hFFFF_FFFF && higha == 32'd0 && !$isunknown(in_beat))
        else $error("Address range changed before any data record.");

endmodule

bind intel_hex_record_decoder_top ihex_checker u_ihex_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
